// ===== hdl/biou_pkg.sv =====
// Shared constants and types for the box intersection-over-union block.
package biou_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int RATIO_BITS     = 17;

    typedef struct packed {
        logic valid;
        logic invalid;
        logic zero;
        logic full;
    } biou_ctrl_t;

endpackage

// ===== hdl/box_intersection_over_union_top.sv =====
// Box intersection over union: front pipeline, row of divider cells, output skid.
//
//  channel   handshake             payload
//  request   req_valid/req_ready   a_xmin..a_ymax, b_xmin..b_ymax
//  result    res_valid/res_ready   overlap_ratio, box_invalid
//
// One request per cycle while the skid stage is empty; three front stages,
// one divider cell per fraction bit, then the output register.
// Reset clears all valid flags; payload registers are not reset.
// The whole pipe holds while the skid stage is full; req_ready is registered.
module box_intersection_over_union_top
    import biou_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [COORD_BITS-1:0] a_xmin,
    input  logic [COORD_BITS-1:0] a_xmax,
    input  logic [COORD_BITS-1:0] a_ymin,
    input  logic [COORD_BITS-1:0] a_ymax,
    input  logic [COORD_BITS-1:0] b_xmin,
    input  logic [COORD_BITS-1:0] b_xmax,
    input  logic [COORD_BITS-1:0] b_ymin,
    input  logic [COORD_BITS-1:0] b_ymax,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [RATIO_BITS-1:0] overlap_ratio,
    output logic                  box_invalid
);

    localparam int AW = 2 * COORD_BITS + 2;
    localparam int RW = FRAC_BITS + 1;
    localparam int DW = RATIO_BITS + 1;

    logic          en;
    biou_ctrl_t    ctrl_w [0:FRAC_BITS];
    logic [AW-1:0] rem_w  [0:FRAC_BITS];
    logic [AW-1:0] den_w  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_w [0:FRAC_BITS];
    logic [RW-1:0] ratio_full;
    logic [DW-1:0] res_data, out_data;
    biou_ctrl_t    last;

    biou_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .valid  (req_valid),
        .a_xmin (a_xmin),
        .a_xmax (a_xmax),
        .a_ymin (a_ymin),
        .a_ymax (a_ymax),
        .b_xmin (b_xmin),
        .b_xmax (b_xmax),
        .b_ymin (b_ymin),
        .b_ymax (b_ymax),
        .ctrl   (ctrl_w[0]),
        .num    (rem_w[0]),
        .den    (den_w[0])
    );

    assign q_w[0] = '0;

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_cell
        biou_div_cell #(
            .AW (AW),
            .QW (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_w[k]),
            .rem_in   (rem_w[k]),
            .den_in   (den_w[k]),
            .q_in     (q_w[k]),
            .ctrl_out (ctrl_w[k+1]),
            .rem_out  (rem_w[k+1]),
            .den_out  (den_w[k+1]),
            .q_out    (q_w[k+1])
        );
    end

    // intersection equal to union gives exactly one; empty or invalid give zero
    always_comb
    begin
        last = ctrl_w[FRAC_BITS];
        if (last.zero)
        begin
            ratio_full = '0;
        end
        else if (last.full)
        begin
            ratio_full = {1'b1, {FRAC_BITS{1'b0}}};
        end
        else
        begin
            ratio_full = {1'b0, q_w[FRAC_BITS]};
        end
        res_data = {last.invalid, RATIO_BITS'(ratio_full)};
    end

    biou_skid #(
        .DW (DW)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (last.valid),
        .in_ready  (en),
        .in_data   (res_data),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (out_data)
    );

    assign req_ready     = en;
    assign overlap_ratio = out_data[RATIO_BITS-1:0];
    assign box_invalid   = out_data[RATIO_BITS];

endmodule

// ===== hdl/biou_front.sv =====
// Front pipeline: spans and checks, areas, then union and the full-overlap flag.
module biou_front
    import biou_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid,
    input  logic [COORD_BITS-1:0]   a_xmin,
    input  logic [COORD_BITS-1:0]   a_xmax,
    input  logic [COORD_BITS-1:0]   a_ymin,
    input  logic [COORD_BITS-1:0]   a_ymax,
    input  logic [COORD_BITS-1:0]   b_xmin,
    input  logic [COORD_BITS-1:0]   b_xmax,
    input  logic [COORD_BITS-1:0]   b_ymin,
    input  logic [COORD_BITS-1:0]   b_ymax,
    output biou_ctrl_t              ctrl,
    output logic [2*COORD_BITS+1:0] num,
    output logic [2*COORD_BITS+1:0] den
);

    localparam int SW = COORD_BITS + 1;
    localparam int AW = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] left, right, top, bottom;
    logic                  invalid_c, empty_c;

    biou_ctrl_t    ctrl_a_reg, ctrl_a_next;
    biou_ctrl_t    ctrl_b_reg, ctrl_b_next;
    biou_ctrl_t    ctrl_c_reg, ctrl_c_next;
    logic [SW-1:0] span_ax_reg, span_ay_reg, span_bx_reg, span_by_reg;
    logic [SW-1:0] span_ix_reg, span_iy_reg;
    logic [AW-1:0] area_a_reg, area_b_reg, area_i_reg;
    logic [AW-1:0] uni_c;
    logic [AW-1:0] num_reg, den_reg;

    always_comb
    begin
        left      = (a_xmin > b_xmin) ? a_xmin : b_xmin;
        right     = (a_xmax < b_xmax) ? a_xmax : b_xmax;
        top       = (a_ymin > b_ymin) ? a_ymin : b_ymin;
        bottom    = (a_ymax < b_ymax) ? a_ymax : b_ymax;
        invalid_c = !(a_xmin < a_xmax) || !(a_ymin < a_ymax)
                 || !(b_xmin < b_xmax) || !(b_ymin < b_ymax);
        empty_c   = (right < left) || (bottom < top);

        ctrl_a_next         = '0;
        ctrl_a_next.valid   = valid;
        ctrl_a_next.invalid = invalid_c;
        ctrl_a_next.zero    = invalid_c || empty_c;

        ctrl_b_next = ctrl_a_reg;

        uni_c            = area_a_reg + area_b_reg - area_i_reg;
        ctrl_c_next      = ctrl_b_reg;
        ctrl_c_next.full = area_i_reg >= uni_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
        end
        else if (en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
            ctrl_c_reg <= ctrl_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span_ax_reg <= SW'(a_xmax) - SW'(a_xmin) + SW'(1);
            span_ay_reg <= SW'(a_ymax) - SW'(a_ymin) + SW'(1);
            span_bx_reg <= SW'(b_xmax) - SW'(b_xmin) + SW'(1);
            span_by_reg <= SW'(b_ymax) - SW'(b_ymin) + SW'(1);
            span_ix_reg <= SW'(right) - SW'(left) + SW'(1);
            span_iy_reg <= SW'(bottom) - SW'(top) + SW'(1);

            area_a_reg  <= AW'(span_ax_reg) * AW'(span_ay_reg);
            area_b_reg  <= AW'(span_bx_reg) * AW'(span_by_reg);
            area_i_reg  <= AW'(span_ix_reg) * AW'(span_iy_reg);

            num_reg     <= area_i_reg;
            den_reg     <= uni_c;
        end
    end

    assign ctrl = ctrl_c_reg;
    assign num  = num_reg;
    assign den  = den_reg;

endmodule

// ===== hdl/biou_div_cell.sv =====
// One restoring-division cell: yields one quotient bit and passes on the remainder.
module biou_div_cell
    import biou_pkg::*;
#(
    parameter int AW = 2 * COORD_BITS_DEF + 2,
    parameter int QW = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  biou_ctrl_t    ctrl_in,
    input  logic [AW-1:0] rem_in,
    input  logic [AW-1:0] den_in,
    input  logic [QW-1:0] q_in,
    output biou_ctrl_t    ctrl_out,
    output logic [AW-1:0] rem_out,
    output logic [AW-1:0] den_out,
    output logic [QW-1:0] q_out
);

    biou_ctrl_t  ctrl_reg;
    logic [AW:0] sh, diff;
    logic        ge;
    logic [AW-1:0] rem_next, rem_reg, den_reg;
    logic [QW-1:0] q_next, q_reg;

    always_comb
    begin
        sh       = {rem_in, 1'b0};
        ge       = sh >= {1'b0, den_in};
        diff     = sh - {1'b0, den_in};
        rem_next = ge ? diff[AW-1:0] : sh[AW-1:0];
        q_next   = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign q_out    = q_reg;

endmodule

// ===== hdl/biou_skid.sv =====
// Output register with a skid stage so upstream ready depends on registers only.
module biou_skid
    import biou_pkg::*;
#(
    parameter int DW = RATIO_BITS + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg, out_valid_next;
    logic          sk_valid_reg, sk_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;
    logic [DW-1:0] sk_data_reg, sk_data_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sk_valid_next  = sk_valid_reg;
        sk_data_next   = sk_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (sk_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = sk_data_reg;
                sk_valid_next  = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid && !sk_valid_reg)
        begin
            sk_valid_next = 1'b1;
            sk_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sk_valid_reg  <= sk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        sk_data_reg  <= sk_data_next;
    end

    assign in_ready  = !sk_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the box intersection-over-union block.
`timescale 1ns / 1ps

module testbench;
    import biou_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int COORD_TOP    = (1 << CW) - 1;
    localparam int PIPE_LATENCY = FRAC + 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_ITEMS  = 160;
    localparam int RATIO_ONE    = 1 << FRAC;

    typedef struct packed {
        logic [CW-1:0] a_xmin;
        logic [CW-1:0] a_xmax;
        logic [CW-1:0] a_ymin;
        logic [CW-1:0] a_ymax;
        logic [CW-1:0] b_xmin;
        logic [CW-1:0] b_xmax;
        logic [CW-1:0] b_ymin;
        logic [CW-1:0] b_ymax;
    } box_pair_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  invalid;
    } iou_result_t;

    typedef struct {
        box_pair_t   boxes;
        bit          known;
        iou_result_t result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [CW-1:0] a_xmin = '0;
    logic [CW-1:0] a_xmax = '0;
    logic [CW-1:0] a_ymin = '0;
    logic [CW-1:0] a_ymax = '0;
    logic [CW-1:0] b_xmin = '0;
    logic [CW-1:0] b_xmax = '0;
    logic [CW-1:0] b_ymin = '0;
    logic [CW-1:0] b_ymax = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic box_invalid;

    iou_result_t pending_ratios[$];
    stim_row_t   directed_rows[$];
    int          mismatches = 0;
    int          rx_stall_pct = 0;
    int          hold_seq = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    box_intersection_over_union_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .a_xmin        (a_xmin),
        .a_xmax        (a_xmax),
        .a_ymin        (a_ymin),
        .a_ymax        (a_ymax),
        .b_xmin        (b_xmin),
        .b_xmax        (b_xmax),
        .b_ymin        (b_ymin),
        .b_ymax        (b_ymax),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .overlap_ratio (overlap_ratio),
        .box_invalid   (box_invalid)
    );

    always #10 clk = ~clk;

    function automatic iou_result_t predict_overlap(box_pair_t p);
        longint unsigned left, right, top, bottom;
        longint unsigned i_area, a_area, b_area, u_area, ratio;
        iou_result_t r;
        ratio = 0;
        r.invalid = !(p.a_xmin < p.a_xmax) || !(p.a_ymin < p.a_ymax) ||
                    !(p.b_xmin < p.b_xmax) || !(p.b_ymin < p.b_ymax);
        if (!r.invalid)
        begin
            left   = (p.a_xmin > p.b_xmin) ? p.a_xmin : p.b_xmin;
            right  = (p.a_xmax < p.b_xmax) ? p.a_xmax : p.b_xmax;
            top    = (p.a_ymin > p.b_ymin) ? p.a_ymin : p.b_ymin;
            bottom = (p.a_ymax < p.b_ymax) ? p.a_ymax : p.b_ymax;
            if (right >= left && bottom >= top)
            begin
                i_area = (right - left + 1) * (bottom - top + 1);
                a_area = (64'(p.a_xmax) - p.a_xmin + 1) * (64'(p.a_ymax) - p.a_ymin + 1);
                b_area = (64'(p.b_xmax) - p.b_xmin + 1) * (64'(p.b_ymax) - p.b_ymin + 1);
                u_area = a_area + b_area - i_area;
                ratio  = (i_area >= u_area) ? 64'(RATIO_ONE) : (i_area << FRAC) / u_area;
            end
        end
        r.ratio = ratio[RATIO_BITS-1:0];
        return r;
    endfunction

    function automatic void add_row(input int axn, input int axx, input int ayn, input int ayx,
                                    input int bxn, input int bxx, input int byn, input int byx,
                                    input bit known, input int ratio, input bit inv);
        stim_row_t row;
        row.boxes  = '{CW'(axn), CW'(axx), CW'(ayn), CW'(ayx),
                       CW'(bxn), CW'(bxx), CW'(byn), CW'(byx)};
        row.known  = known;
        row.result = known ? iou_result_t'{RATIO_BITS'(ratio), inv} : predict_overlap(row.boxes);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic int pick_width();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(63, 1);
        else if (sel < 90)
            return $urandom_range(4095, 1);
        return $urandom_range(COORD_TOP, 1);
    endfunction

    function automatic void rand_span(output int lo, output int hi);
        int w;
        w  = pick_width();
        lo = $urandom_range(COORD_TOP - w, 0);
        hi = lo + w;
    endfunction

    // span overlapping [lo_a, hi_a], kept close to it
    function automatic void near_span(input int lo_a, input int hi_a, output int lo, output int hi);
        int w;
        int lim;
        w   = pick_width();
        lim = (lo_a > w) ? lo_a - w : 0;
        lo  = $urandom_range(hi_a, lim);
        if (lo > COORD_TOP - 1)
            lo = COORD_TOP - 1;
        hi  = $urandom_range((lo + 1 > lo_a) ? lo + 1 : lo_a,
                             (hi_a + w > COORD_TOP) ? COORD_TOP : hi_a + w);
    endfunction

    function automatic box_pair_t random_box_pair();
        int axn, axx, ayn, ayx, bxn, bxx, byn, byx;
        int sel;
        box_pair_t p;
        sel = $urandom_range(99);
        rand_span(axn, axx);
        rand_span(ayn, ayx);
        if (sel < 60)
        begin
            near_span(axn, axx, bxn, bxx);
            near_span(ayn, ayx, byn, byx);
        end
        else if (sel < 75)
        begin
            rand_span(bxn, bxx);
            rand_span(byn, byx);
        end
        else if (sel < 85)
        begin
            bxn = axn; bxx = axx; byn = ayn; byx = ayx;
        end
        else if (sel < 90)
        begin
            // boxes sharing one column
            bxn = axx;
            bxx = (axx == COORD_TOP) ? COORD_TOP : $urandom_range(COORD_TOP, axx + 1);
            near_span(ayn, ayx, byn, byx);
        end
        else
        begin
            axn = $urandom_range(COORD_TOP); axx = $urandom_range(COORD_TOP);
            ayn = $urandom_range(COORD_TOP); ayx = $urandom_range(COORD_TOP);
            bxn = $urandom_range(COORD_TOP); bxx = $urandom_range(COORD_TOP);
            byn = $urandom_range(COORD_TOP); byx = $urandom_range(COORD_TOP);
        end
        p = '{CW'(axn), CW'(axx), CW'(ayn), CW'(ayx),
              CW'(bxn), CW'(bxx), CW'(byn), CW'(byx)};
        return p;
    endfunction

    // called at a clock edge; returns at the edge that accepts the request
    task automatic offer_boxes(input box_pair_t p, input iou_result_t e, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        a_xmin <= p.a_xmin;
        a_xmax <= p.a_xmax;
        a_ymin <= p.a_ymin;
        a_ymax <= p.a_ymax;
        b_xmin <= p.b_xmin;
        b_xmax <= p.b_xmax;
        b_ymin <= p.b_ymin;
        b_ymax <= p.b_ymax;
        do
            @(posedge clk);
        while (!req_ready);
        pending_ratios.insert(pending_ratios.size(), e);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_ratios.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        iou_result_t e;
        if (res_valid && res_ready)
        begin
            if (pending_ratios.size() == 0)
            begin
                $display("%0t: unexpected result, overlap_ratio %0d box_invalid %0b",
                         $time, overlap_ratio, box_invalid);
                mismatches++;
            end
            else
            begin
                e = pending_ratios.pop_front();
                if (overlap_ratio !== e.ratio)
                begin
                    $display("%0t: overlap_ratio expected %0d, actual %0d",
                             $time, e.ratio, overlap_ratio);
                    mismatches++;
                end
                if (box_invalid !== e.invalid)
                begin
                    $display("%0t: box_invalid expected %0b, actual %0b",
                             $time, e.invalid, box_invalid);
                    mismatches++;
                end
            end
        end
        if (hold_ack != hold_seq)
        begin
            hold_ack  = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int tx_idle;
        box_pair_t p;

        // identical extents, full range and small
        add_row(0, COORD_TOP, 0, COORD_TOP, 0, COORD_TOP, 0, COORD_TOP, 1, RATIO_ONE, 0);
        add_row(10, 20, 10, 20, 10, 20, 10, 20, 1, RATIO_ONE, 0);
        // invalid boxes
        add_row(5, 5, 0, 9, 0, 9, 0, 9, 1, 0, 1);
        add_row(0, 9, COORD_TOP, 0, 0, 9, 0, 9, 1, 0, 1);
        add_row(0, 9, 0, 9, COORD_TOP, 0, 0, 9, 1, 0, 1);
        add_row(0, 9, 0, 9, 0, 9, 7, 7, 1, 0, 1);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1);
        add_row(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP,
                COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, 1, 0, 1);
        // disjoint on one axis or on both
        add_row(0, 9, 0, 9, 10, 20, 0, 9, 1, 0, 0);
        add_row(0, 9, 0, 9, 0, 9, 10, COORD_TOP, 1, 0, 0);
        add_row(0, 1, 0, 1, COORD_TOP - 1, COORD_TOP, COORD_TOP - 1, COORD_TOP, 1, 0, 0);
        // containment
        add_row(0, COORD_TOP, 0, COORD_TOP, 0, 1, 0, 1, 1, 0, 0);
        add_row(0, 3, 0, 1, 0, 1, 0, 1, 1, RATIO_ONE / 2, 0);
        // shared edge, corner overlap, near-full, crossing strips
        add_row(0, 10, 0, 1, 10, 20, 0, 1, 0, 0, 0);
        add_row(0, 1, 0, 1, 1, 2, 1, 2, 0, 0, 0);
        add_row(0, COORD_TOP, 0, COORD_TOP, 1, COORD_TOP - 1, 1, COORD_TOP - 1, 0, 0, 0);
        add_row(0, COORD_TOP, 0, COORD_TOP, 0, COORD_TOP, 0, COORD_TOP - 1, 0, 0, 0);
        add_row(COORD_TOP - 1, COORD_TOP, 0, COORD_TOP, 0, COORD_TOP, COORD_TOP - 1, COORD_TOP,
                0, 0, 0);
        // alternating and other bit patterns
        add_row('h5555, 'haaaa, 'h5555, 'haaaa, 'h2aaa, 'hd555, 'h2aaa, 'hd555, 0, 0, 0);
        add_row('h1234, 'hfedc, 'h0f0f, 'hf0f0, 'h00ff, 'hff00, 'h3333, 'hcccc, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_boxes(directed_rows[i].boxes, directed_rows[i].result, 0);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle = 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_idle = 83;
                    rx_stall_pct <= 0;
                end
                2:
                begin
                    tx_idle = 0;
                    rx_stall_pct <= 83;
                end
                default:
                begin
                    tx_idle = 22;
                    rx_stall_pct <= 22;
                end
            endcase
            // long receiver hold-off with the sender still pushing
            if (phase == 0 || phase == 2)
                hold_seq <= hold_seq + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p = random_box_pair();
                offer_boxes(p, predict_overlap(p), (phase == 2 && n < 40) ? 0 : tx_idle);
            end
            if (phase == 1)
                drain_results();
        end

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
